FILE: design/imheq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the indexed min-heap event queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package imheq_pkg;

	localparam int NODE_COUNT = 1024;
	localparam int ID_W       = 10;
	localparam int CNT_W      = 11;
	localparam int KEY_W      = 32;

	typedef enum logic [1:0] {
		ACT_INSERT   = 2'd0,
		ACT_POP      = 2'd1,
		ACT_DECREASE = 2'd2,
		ACT_NONE     = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_NODE_BAD = 3'd3,
		ST_KEY_INC  = 3'd4
	} status_t;

	// micro-operations issued by the controller to the datapath
	typedef enum logic [4:0] {
		OP_NOP,
		OP_CLEAR,
		OP_LOAD,
		OP_RD_POS,
		OP_POP_ROOT,
		OP_POP_LAST,
		OP_POP_TAKE,
		OP_INS_CHK,
		OP_DEC_CHK,
		OP_DEC_KEY,
		OP_UP_RD,
		OP_UP_CMP,
		OP_DN_LEFT,
		OP_DN_RIGHT,
		OP_DN_CHOOSE,
		OP_PLACE,
		OP_RESP
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic    clear_done;
		logic    out_busy;
		action_t act;
		logic    empty;
		logic    ins_ok;
		logic    dec_ok;
		logic    key_ok;
		logic    last_gone;
		logic    up_top;
		logic    up_stop;
		logic    dn_leaf;
		logic    dn_stop;
	} stat_t;

endpackage

FILE: design/indexed_min_heap_event_queue.sv
`timescale 1ns / 1ps
// Indexed min-heap event queue: a 1-rooted binary heap of node ids keyed by time.
// Input beat: action, node_id, key_value on in_valid/in_stall.
// Output beat: out_node, out_key, status, entry_total on out_valid/out_stall.
// One output beat per input beat, in order. Actions: insert, pop minimum,
// decrease key; errors report a status and leave the heap untouched.
// Insert and decrease-key climb the heap one level at a time, reading the
// parent at each level; pop descends one level at a time, reading both
// children. The heap holds up to 1024 entries in a single-port memory
// that is read with registered data.
// One item is worked at a time; the next is taken once the previous result
// has left the output register.
// After reset the node position table is swept to zero, with in_stall high.
// A stalled output beat holds its payload, and the block takes no new input
// beat until it is delivered.
// Depends on imheq_pkg, imheq_ctrl and imheq_datapath.
module indexed_min_heap_event_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  action,
	input  logic [imheq_pkg::ID_W-1:0]  node_id,
	input  logic [imheq_pkg::KEY_W-1:0] key_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [imheq_pkg::ID_W-1:0]  out_node,
	output logic [imheq_pkg::KEY_W-1:0] out_key,
	output logic [2:0]                  status,
	output logic [imheq_pkg::CNT_W-1:0] entry_total
);

	imheq_pkg::cmd_t  cmd;
	imheq_pkg::stat_t stat;

	// sequencer
	imheq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// memories and working registers
	imheq_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.action      (action),
		.node_id     (node_id),
		.key_value   (key_value),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_node    (out_node),
		.out_key     (out_key),
		.status      (status),
		.entry_total (entry_total)
	);

endmodule

FILE: design/imheq_datapath.sv
`timescale 1ns / 1ps
// Datapath: heap, position memories, working registers and the result register.
// Depends on imheq_pkg; driven by imheq_ctrl through cmd_t, reports stat_t.
module imheq_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  imheq_pkg::cmd_t            cmd,
	output imheq_pkg::stat_t           stat,
	input  logic [1:0]                 action,
	input  logic [imheq_pkg::ID_W-1:0] node_id,
	input  logic [imheq_pkg::KEY_W-1:0] key_value,
	input  logic                       out_stall,
	output logic                       out_valid,
	output logic [imheq_pkg::ID_W-1:0] out_node,
	output logic [imheq_pkg::KEY_W-1:0] out_key,
	output logic [2:0]                 status,
	output logic [imheq_pkg::CNT_W-1:0] entry_total
);

	localparam int ID_W  = imheq_pkg::ID_W;
	localparam int CNT_W = imheq_pkg::CNT_W;
	localparam int KEY_W = imheq_pkg::KEY_W;
	localparam int DEPTH = imheq_pkg::NODE_COUNT;

	// memories: heap slot s lives at address s-1
	logic [ID_W-1:0]  heap_node_mem [DEPTH];
	logic [KEY_W-1:0] heap_key_mem  [DEPTH];
	logic [CNT_W-1:0] pos_mem       [DEPTH];

	logic [ID_W-1:0]  hrd_node_q;
	logic [KEY_W-1:0] hrd_key_q;
	logic [CNT_W-1:0] prd_q;

	// working registers
	imheq_pkg::action_t act_q;
	logic [ID_W-1:0]  id_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cur_q;
	logic [ID_W-1:0]  mv_node_q;
	logic [KEY_W-1:0] mv_key_q;
	logic [CNT_W-1:0] bst_q;
	logic [ID_W-1:0]  bnode_q;
	logic [KEY_W-1:0] bkey_q;
	imheq_pkg::status_t st_q;
	logic [ID_W-1:0]  res_node_q;
	logic [KEY_W-1:0] res_key_q;
	logic [CNT_W-1:0] clr_q;
	logic             out_valid_q;
	logic [ID_W-1:0]  out_node_q;
	logic [KEY_W-1:0] out_key_q;
	logic [2:0]       status_q;
	logic [CNT_W-1:0] total_q;

	// derived values
	logic [CNT_W:0]   left_w;
	logic [CNT_W:0]   right_w;
	logic [CNT_W:0]   cnt_w;
	logic [CNT_W-1:0] cur_m1;
	logic [CNT_W-1:0] par_w;
	logic [CNT_W-1:0] par_m1;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] prd_m1;
	logic [CNT_W-1:0] left_m1;
	logic [CNT_W-1:0] right_m1;
	logic             id_ok;
	logic             full;
	logic             right_in;
	logic             right_win;
	logic [CNT_W-1:0] fin_best;
	logic [ID_W-1:0]  fin_node;
	logic [KEY_W-1:0] fin_key;

	// memory port controls
	logic             hre;
	logic [ID_W-1:0]  hra;
	logic             hwe;
	logic [ID_W-1:0]  hwa;
	logic [ID_W-1:0]  hw_node;
	logic [KEY_W-1:0] hw_key;
	logic             pre;
	logic [ID_W-1:0]  pra;
	logic             pwe;
	logic [ID_W-1:0]  pwa;
	logic [CNT_W-1:0] pwd;

	assign left_w   = {cur_q, 1'b0};
	assign right_w  = left_w + (CNT_W+1)'(1);
	assign cnt_w    = {1'b0, cnt_q};
	assign cur_m1   = cur_q - CNT_W'(1);
	assign par_w    = cur_q >> 1;
	assign par_m1   = par_w - CNT_W'(1);
	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign prd_m1   = prd_q - CNT_W'(1);
	assign left_m1  = left_w[CNT_W-1:0] - CNT_W'(1);
	assign right_m1 = right_w[CNT_W-1:0] - CNT_W'(1);
	assign id_ok    = {1'b0, id_q} < CNT_W'(DEPTH);
	assign full     = cnt_q == CNT_W'(DEPTH);
	assign right_in = right_w <= cnt_w;
	assign right_win = right_in && (hrd_key_q < bkey_q);
	assign fin_best = right_win ? right_w[CNT_W-1:0] : bst_q;
	assign fin_node = right_win ? hrd_node_q : bnode_q;
	assign fin_key  = right_win ? hrd_key_q : bkey_q;

	// status toward the controller
	always_comb begin
		stat.clear_done = clr_q == CNT_W'(DEPTH);
		stat.out_busy   = out_valid_q;
		stat.act        = act_q;
		stat.empty      = cnt_q == '0;
		stat.ins_ok     = !full && id_ok && prd_q == '0;
		stat.dec_ok     = id_ok && prd_q != '0;
		stat.key_ok     = !(key_q > hrd_key_q);
		stat.last_gone  = cnt_q == CNT_W'(1);
		stat.up_top     = cur_q == CNT_W'(1);
		stat.up_stop    = !(mv_key_q < hrd_key_q);
		stat.dn_leaf    = left_w > cnt_w;
		stat.dn_stop    = fin_best == cur_q;
	end

	// memory addressing per micro-operation
	always_comb begin
		hre     = 1'b0;
		hra     = '0;
		hwe     = 1'b0;
		hwa     = cur_m1[ID_W-1:0];
		hw_node = mv_node_q;
		hw_key  = mv_key_q;
		pre     = 1'b0;
		pra     = id_q;
		pwe     = 1'b0;
		pwa     = mv_node_q;
		pwd     = cur_q;
		case (cmd.op)
			imheq_pkg::OP_CLEAR: begin
				pwe = 1'b1;
				pwa = clr_q[ID_W-1:0];
				pwd = '0;
			end
			imheq_pkg::OP_RD_POS: begin
				pre = 1'b1;
			end
			imheq_pkg::OP_POP_ROOT: begin
				hre = 1'b1;
			end
			imheq_pkg::OP_POP_LAST: begin
				hre = 1'b1;
				hra = cnt_m1[ID_W-1:0];
				pwe = 1'b1;
				pwa = hrd_node_q;
				pwd = '0;
			end
			imheq_pkg::OP_DEC_CHK: begin
				hre = 1'b1;
				hra = prd_m1[ID_W-1:0];
			end
			imheq_pkg::OP_UP_RD: begin
				hre = 1'b1;
				hra = par_m1[ID_W-1:0];
			end
			imheq_pkg::OP_UP_CMP: begin
				if (!stat.up_stop) begin
					hwe     = 1'b1;
					hw_node = hrd_node_q;
					hw_key  = hrd_key_q;
					pwe     = 1'b1;
					pwa     = hrd_node_q;
				end
			end
			imheq_pkg::OP_DN_LEFT: begin
				hre = 1'b1;
				hra = left_m1[ID_W-1:0];
			end
			imheq_pkg::OP_DN_RIGHT: begin
				hre = 1'b1;
				hra = right_m1[ID_W-1:0];
			end
			imheq_pkg::OP_DN_CHOOSE: begin
				if (!stat.dn_stop) begin
					hwe     = 1'b1;
					hw_node = fin_node;
					hw_key  = fin_key;
					pwe     = 1'b1;
					pwa     = fin_node;
				end
			end
			imheq_pkg::OP_PLACE: begin
				hwe = 1'b1;
				pwe = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// memory ports with registered read data
	always_ff @(posedge clk) begin
		if (hwe) begin
			heap_node_mem[hwa] <= hw_node;
			heap_key_mem[hwa]  <= hw_key;
		end
		if (hre) begin
			hrd_node_q <= heap_node_mem[hra];
			hrd_key_q  <= heap_key_mem[hra];
		end
		if (pwe) begin
			pos_mem[pwa] <= pwd;
		end
		if (pre) begin
			prd_q <= pos_mem[pra];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				imheq_pkg::OP_CLEAR: clr_q <= clr_q + CNT_W'(1);
				imheq_pkg::OP_POP_TAKE: cnt_q <= cnt_m1;
				imheq_pkg::OP_INS_CHK: begin
					if (stat.ins_ok) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				imheq_pkg::OP_RESP: out_valid_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	// working payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			imheq_pkg::OP_LOAD: begin
				act_q      <= imheq_pkg::action_t'(action);
				id_q       <= node_id;
				key_q      <= key_value;
				st_q       <= imheq_pkg::ST_OK;
				res_node_q <= '0;
				res_key_q  <= '0;
			end
			imheq_pkg::OP_POP_ROOT: begin
				if (stat.empty) begin
					st_q <= imheq_pkg::ST_EMPTY;
				end
			end
			imheq_pkg::OP_POP_LAST: begin
				res_node_q <= hrd_node_q;
				res_key_q  <= hrd_key_q;
			end
			imheq_pkg::OP_POP_TAKE: begin
				mv_node_q <= hrd_node_q;
				mv_key_q  <= hrd_key_q;
				cur_q     <= CNT_W'(1);
			end
			imheq_pkg::OP_INS_CHK: begin
				if (full) begin
					st_q <= imheq_pkg::ST_FULL;
				end else if (!stat.ins_ok) begin
					st_q <= imheq_pkg::ST_NODE_BAD;
				end
				cur_q     <= cnt_q + CNT_W'(1);
				mv_node_q <= id_q;
				mv_key_q  <= key_q;
			end
			imheq_pkg::OP_DEC_CHK: begin
				if (!stat.dec_ok) begin
					st_q <= imheq_pkg::ST_NODE_BAD;
				end
				cur_q <= prd_q;
			end
			imheq_pkg::OP_DEC_KEY: begin
				if (!stat.key_ok) begin
					st_q <= imheq_pkg::ST_KEY_INC;
				end
				mv_node_q <= id_q;
				mv_key_q  <= key_q;
			end
			imheq_pkg::OP_UP_CMP: begin
				if (!stat.up_stop) begin
					cur_q <= par_w;
				end
			end
			imheq_pkg::OP_DN_LEFT: begin
				bst_q   <= cur_q;
				bnode_q <= mv_node_q;
				bkey_q  <= mv_key_q;
			end
			imheq_pkg::OP_DN_RIGHT: begin
				if (hrd_key_q < bkey_q) begin
					bst_q   <= left_w[CNT_W-1:0];
					bnode_q <= hrd_node_q;
					bkey_q  <= hrd_key_q;
				end
			end
			imheq_pkg::OP_DN_CHOOSE: cur_q <= fin_best;
			imheq_pkg::OP_RESP: begin
				out_node_q <= res_node_q;
				out_key_q  <= res_key_q;
				status_q   <= st_q;
				total_q    <= cnt_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign out_node    = out_node_q;
	assign out_key     = out_key_q;
	assign status      = status_q;
	assign entry_total = total_q;

endmodule

FILE: design/imheq_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences insert, pop and decrease-key operations.
// Depends on imheq_pkg; drives cmd_t to imheq_datapath and reads its stat_t.
module imheq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  imheq_pkg::stat_t stat,
	output imheq_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISP,
		S_POP_LAST,
		S_POP_TAKE,
		S_INS_CHK,
		S_DEC_CHK,
		S_DEC_KEY,
		S_UP_RD,
		S_UP_CMP,
		S_DN_LEFT,
		S_DN_RIGHT,
		S_DN_CHOOSE,
		S_PLACE,
		S_RESP
	} state_t;

	state_t state_q;

	assign in_stall = state_q != S_IDLE || stat.out_busy;

	// micro-operation for the current state
	always_comb begin
		cmd.op = imheq_pkg::OP_NOP;
		case (state_q)
			S_CLEAR: begin
				if (!stat.clear_done) begin
					cmd.op = imheq_pkg::OP_CLEAR;
				end
			end
			S_IDLE: begin
				if (in_valid && !stat.out_busy) begin
					cmd.op = imheq_pkg::OP_LOAD;
				end
			end
			S_DISP: begin
				case (stat.act)
					imheq_pkg::ACT_INSERT, imheq_pkg::ACT_DECREASE:
						cmd.op = imheq_pkg::OP_RD_POS;
					imheq_pkg::ACT_POP: cmd.op = imheq_pkg::OP_POP_ROOT;
					default: cmd.op = imheq_pkg::OP_NOP;
				endcase
			end
			S_POP_LAST:  cmd.op = imheq_pkg::OP_POP_LAST;
			S_POP_TAKE:  cmd.op = imheq_pkg::OP_POP_TAKE;
			S_INS_CHK:   cmd.op = imheq_pkg::OP_INS_CHK;
			S_DEC_CHK:   cmd.op = imheq_pkg::OP_DEC_CHK;
			S_DEC_KEY:   cmd.op = imheq_pkg::OP_DEC_KEY;
			S_UP_RD:     cmd.op = imheq_pkg::OP_UP_RD;
			S_UP_CMP:    cmd.op = imheq_pkg::OP_UP_CMP;
			S_DN_LEFT:   cmd.op = imheq_pkg::OP_DN_LEFT;
			S_DN_RIGHT:  cmd.op = imheq_pkg::OP_DN_RIGHT;
			S_DN_CHOOSE: cmd.op = imheq_pkg::OP_DN_CHOOSE;
			S_PLACE:     cmd.op = imheq_pkg::OP_PLACE;
			S_RESP:      cmd.op = imheq_pkg::OP_RESP;
			default:     cmd.op = imheq_pkg::OP_NOP;
		endcase
	end

	// advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: if (stat.clear_done) state_q <= S_IDLE;
				S_IDLE: begin
					if (in_valid && !stat.out_busy) state_q <= S_DISP;
				end
				S_DISP: begin
					case (stat.act)
						imheq_pkg::ACT_INSERT:   state_q <= S_INS_CHK;
						imheq_pkg::ACT_DECREASE: state_q <= S_DEC_CHK;
						imheq_pkg::ACT_POP:
							state_q <= stat.empty ? S_RESP : S_POP_LAST;
						default: state_q <= S_RESP;
					endcase
				end
				S_POP_LAST: state_q <= S_POP_TAKE;
				S_POP_TAKE: state_q <= stat.last_gone ? S_RESP : S_DN_LEFT;
				S_INS_CHK:  state_q <= stat.ins_ok ? S_UP_RD : S_RESP;
				S_DEC_CHK:  state_q <= stat.dec_ok ? S_DEC_KEY : S_RESP;
				S_DEC_KEY:  state_q <= stat.key_ok ? S_UP_RD : S_RESP;
				S_UP_RD:    state_q <= stat.up_top ? S_PLACE : S_UP_CMP;
				S_UP_CMP:   state_q <= stat.up_stop ? S_PLACE : S_UP_RD;
				S_DN_LEFT:  state_q <= stat.dn_leaf ? S_PLACE : S_DN_RIGHT;
				S_DN_RIGHT: state_q <= S_DN_CHOOSE;
				S_DN_CHOOSE: state_q <= stat.dn_stop ? S_PLACE : S_DN_LEFT;
				S_PLACE:    state_q <= S_RESP;
				S_RESP:     state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: tb/heap_checker.sv
`timescale 1ns / 1ps
// Checker for the indexed min-heap event queue: watches both channels,
// keeps its own copy of the heap and compares each output beat. Depends on imheq_pkg.
module heap_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [1:0]                  action,
	input  logic [imheq_pkg::ID_W-1:0]  node_id,
	input  logic [imheq_pkg::KEY_W-1:0] key_value,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [imheq_pkg::ID_W-1:0]  out_node,
	input  logic [imheq_pkg::KEY_W-1:0] out_key,
	input  logic [2:0]                  status,
	input  logic [imheq_pkg::CNT_W-1:0] entry_total,
	output int                          fail_count,
	output int                          pending_count
);

	localparam int ID_W       = imheq_pkg::ID_W;
	localparam int KEY_W      = imheq_pkg::KEY_W;
	localparam int CNT_W      = imheq_pkg::CNT_W;
	localparam int NODE_COUNT = imheq_pkg::NODE_COUNT;

	typedef struct packed {
		logic [ID_W-1:0]  node;
		logic [KEY_W-1:0] key;
		logic [2:0]       st;
		logic [CNT_W-1:0] total;
	} heap_result_t;

	logic [ID_W-1:0]  slot_node [1:NODE_COUNT];
	logic [CNT_W-1:0] node_slot [NODE_COUNT];
	logic [KEY_W-1:0] node_time [NODE_COUNT];
	int               queued;
	heap_result_t     expected_results[$];

	assign pending_count = expected_results.size();

	function automatic void swap_slots(int a, int b);
		logic [ID_W-1:0] t;
		t = slot_node[a];
		slot_node[a] = slot_node[b];
		slot_node[b] = t;
		node_slot[slot_node[a]] = CNT_W'(a);
		node_slot[slot_node[b]] = CNT_W'(b);
	endfunction

	function automatic void climb(int pos);
		while (pos > 1 && node_time[slot_node[pos]] < node_time[slot_node[pos/2]]) begin
			swap_slots(pos, pos/2);
			pos = pos/2;
		end
	endfunction

	function automatic void descend(int pos);
		int best;
		int l;
		forever begin
			best = pos;
			l = pos*2;
			if (l <= queued && node_time[slot_node[l]] < node_time[slot_node[best]])
				best = l;
			if (l+1 <= queued && node_time[slot_node[l+1]] < node_time[slot_node[best]])
				best = l+1;
			if (best == pos)
				return;
			swap_slots(best, pos);
			pos = best;
		end
	endfunction

	function automatic heap_result_t apply_beat(logic [1:0] act, int id, logic [KEY_W-1:0] k);
		heap_result_t r;
		int root;
		r = '0;
		r.st = imheq_pkg::ST_OK;
		case (act)
			imheq_pkg::ACT_INSERT: begin
				if (queued >= NODE_COUNT) r.st = imheq_pkg::ST_FULL;
				else if (node_slot[id] != 0) r.st = imheq_pkg::ST_NODE_BAD;
				else begin
					node_time[id] = k;
					queued++;
					slot_node[queued] = ID_W'(id);
					node_slot[id] = CNT_W'(queued);
					climb(queued);
				end
			end
			imheq_pkg::ACT_POP: begin
				if (queued == 0) r.st = imheq_pkg::ST_EMPTY;
				else begin
					root = slot_node[1];
					r.node = ID_W'(root);
					r.key = node_time[root];
					node_slot[root] = 0;
					slot_node[1] = slot_node[queued];
					queued--;
					if (queued > 0) begin
						node_slot[slot_node[1]] = 1;
						descend(1);
					end
				end
			end
			imheq_pkg::ACT_DECREASE: begin
				if (node_slot[id] == 0) r.st = imheq_pkg::ST_NODE_BAD;
				else if (k > node_time[id]) r.st = imheq_pkg::ST_KEY_INC;
				else begin
					node_time[id] = k;
					climb(node_slot[id]);
				end
			end
			default: ;
		endcase
		r.total = CNT_W'(queued);
		return r;
	endfunction

	// predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		heap_result_t want;
		if (!arst_n) begin
			queued = 0;
			fail_count = 0;
			for (int i = 0; i < NODE_COUNT; i++) node_slot[i] = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(apply_beat(action, node_id, key_value));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected beat node=%0d key=%0d status=%0d total=%0d",
						$time, out_node, out_key, status, entry_total);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (want.node !== out_node || want.key !== out_key
							|| want.st !== status || want.total !== entry_total) begin
						$display("%0t: mismatch expected node=%0d key=%0d status=%0d total=%0d",
							$time, want.node, want.key, want.st, want.total);
						$display("%0t:          actual   node=%0d key=%0d status=%0d total=%0d",
							$time, out_node, out_key, status, entry_total);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the event queue testbench: clock, reset, stimulus and verdict.
// Depends on imheq_pkg, heap_checker and the block itself.
module testbench;

	localparam int ID_W       = imheq_pkg::ID_W;
	localparam int KEY_W      = imheq_pkg::KEY_W;
	localparam int CNT_W      = imheq_pkg::CNT_W;
	localparam int NODE_COUNT = imheq_pkg::NODE_COUNT;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       action;
	logic [ID_W-1:0]  node_id;
	logic [KEY_W-1:0] key_value;
	logic             out_valid;
	logic             out_stall;
	logic [ID_W-1:0]  out_node;
	logic [KEY_W-1:0] out_key;
	logic [2:0]       status;
	logic [CNT_W-1:0] entry_total;
	int               fail_count;
	int               pending_count;
	int               send_idle_pct;
	int               recv_idle_pct;
	int               cycle_count;
	int               live_ids[$];

	indexed_min_heap_event_queue dut (.*);
	heap_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// end the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 900000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// randomly stall the output
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	// hold one beat until accepted; valid stays up for a following beat
	task automatic send_beat(logic [1:0] act, int id, logic [KEY_W-1:0] k);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		action <= act;
		node_id <= ID_W'(id);
		key_value <= k;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		if (act == imheq_pkg::ACT_INSERT) live_ids.push_back(id);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(3))
			0: return $urandom_range(15);
			1: return '1 - $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int count, int sp, int rp);
		int sel;
		int id;
		send_idle_pct = sp;
		recv_idle_pct = rp;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			if (live_ids.size() > 0 && $urandom_range(1))
				id = live_ids[$urandom_range(live_ids.size()-1)];
			else
				id = $urandom_range(NODE_COUNT-1);
			if (sel < 45) send_beat(imheq_pkg::ACT_INSERT, id, pick_key());
			else if (sel < 75) send_beat(imheq_pkg::ACT_POP, $urandom, $urandom);
			else if (sel < 97)
				send_beat(imheq_pkg::ACT_DECREASE, id,
					sel < 88 ? $urandom_range(255) : pick_key());
			else send_beat(imheq_pkg::ACT_NONE, id, $urandom);
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		out_stall = 0;
		action = 0;
		node_id = 0;
		key_value = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		cycle_count = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		// directed: empty pop, extremes, every error but full, equal keys
		send_beat(imheq_pkg::ACT_POP, 0, 0);
		send_beat(imheq_pkg::ACT_DECREASE, 5, 0);
		send_beat(imheq_pkg::ACT_INSERT, 0, '1);
		send_beat(imheq_pkg::ACT_INSERT, 1023, 0);
		send_beat(imheq_pkg::ACT_INSERT, 1023, 7);
		send_beat(imheq_pkg::ACT_INSERT, 512, 100);
		send_beat(imheq_pkg::ACT_INSERT, 341, 100);
		send_beat(imheq_pkg::ACT_INSERT, 682, 100);
		send_beat(imheq_pkg::ACT_DECREASE, 512, 200);
		send_beat(imheq_pkg::ACT_DECREASE, 512, 100);
		send_beat(imheq_pkg::ACT_DECREASE, 0, 50);
		send_beat(imheq_pkg::ACT_NONE, 3, 3);
		repeat (7) send_beat(imheq_pkg::ACT_POP, 0, 0);
		in_valid <= 0;
		// sender holds off until the queue drains
		while (pending_count != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		// fill the heap completely, then hit the full case
		for (int i = 0; i < NODE_COUNT; i++)
			send_beat(imheq_pkg::ACT_INSERT, i, $urandom_range(63));
		send_beat(imheq_pkg::ACT_INSERT, 77, 1);
		random_phase(135, 9, 67);
		random_phase(135, 67, 9);
		random_phase(136, 0, 0);
		in_valid <= 0;
		recv_idle_pct = 0;
		while (pending_count != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
